// ----- src/vfv_pkg.sv -----
package vfv_pkg;

    // controller states
    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_DONE
    } state_t;

    // where the read in flight gets its answer
    typedef enum logic [2:0]
    {
        SRC_NONE,
        SRC_CENTER,
        SRC_BLOCK,
        SRC_EDGE,
        SRC_ONE,
        SRC_ZERO
    } src_t;

    // request kinds
    localparam logic [1:0] REQ_WRITE_BLOCK = 2'd0;
    localparam logic [1:0] REQ_WRITE_EDGE  = 2'd1;
    localparam logic [1:0] REQ_QUERY       = 2'd2;

    // neighbor planes
    localparam logic [1:0] SIDE_FRONT = 2'd0;
    localparam logic [1:0] SIDE_BACK  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;
    localparam logic [1:0] SIDE_LEFT  = 2'd3;

    // face bit positions in the mask
    localparam logic [2:0] FACE_POS_Z = 3'd0;
    localparam logic [2:0] FACE_POS_X = 3'd1;
    localparam logic [2:0] FACE_NEG_Z = 3'd2;
    localparam logic [2:0] FACE_NEG_X = 3'd3;
    localparam logic [2:0] FACE_POS_Y = 3'd4;
    localparam logic [2:0] FACE_NEG_Y = 3'd5;

    localparam int FACE_W     = 6;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_W      = 8;

endpackage

// ----- src/vfv_ram.sv -----
module vfv_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/voxel_face_visibility.sv -----
// voxel face visibility
// holds a SIZE_X x SIZE_Y x SIZE_Z chunk of block ids plus four neighbor edge
// planes of air flags, and answers face-visibility queries
// input channel s_*: one word per request, kind in s_tuser (0 write block,
// 1 write edge flag, 2 query, 3 ignored); only a query yields an output word
// output channel m_*: face mask and solid flag, one word per query
// config channel cfg_*: writes the air block id, always ready; the user must
// write it only while idle, the block does not enforce this
// after reset the block sweeps both stores to their reset contents, one entry
// per cycle over max(SIZE_X*SIZE_Y*SIZE_Z, 4*2^ceil(log2(plane size))) entries
// (16384 with default sizes); s_tready stays low during the sweep; a write goes
// to its store in its accept cycle; a query makes the center read at accept and
// six neighbor reads, from the block store or at an x or z border the edge
// store, then loads its word in the collect state; s_tready is low meanwhile
// the output register keeps a finished word while the receiver stalls; the
// block keeps taking writes meanwhile, and a query that finishes while the
// output word is still pending waits in ST_DONE until m_tready
module voxel_face_visibility #(
    parameter int SIZE_X  = 16,
    parameter int SIZE_Y  = 64,
    parameter int SIZE_Z  = 16,
    parameter int ID_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pos_x[3:0], pos_y[9:4], pos_z[13:10], block_id[21:14], edge_side[23:22],
    // neighbor_air[24], zero pad [31:25]
    input  logic [vfv_pkg::IN_DATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [vfv_pkg::IN_USER_W-1:0] s_tuser,
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // face_mask[5:0], is_solid[6], zero pad [7]
    output logic [vfv_pkg::OUT_DATA_W-1:0] m_tdata,
    // air block id register
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vfv_pkg::CFG_W-1:0]     cfg_data
);

    import vfv_pkg::*;

    // store geometry
    localparam int CELLS      = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int CELL_AW    = $clog2(CELLS);
    localparam int PLANE_MAX  = (SIZE_X > SIZE_Z ? SIZE_X : SIZE_Z) * SIZE_Y;
    localparam int PLANE_AW   = $clog2(PLANE_MAX);
    localparam int EDGE_AW    = PLANE_AW + 2;
    localparam int EDGE_DEPTH = 4 << PLANE_AW;
    localparam int CLEAR_LEN  = (CELLS > EDGE_DEPTH) ? CELLS : EDGE_DEPTH;
    localparam int CLR_W      = $clog2(CLEAR_LEN);

    // flat cell index, y outermost then z then x
    function automatic logic [31:0] cell_lin(input logic [31:0] x,
                                             input logic [31:0] y,
                                             input logic [31:0] z);
        return (y * SIZE_Z + z) * SIZE_X + x;
    endfunction

    // index inside one edge plane
    function automatic logic [31:0] plane_lin(input logic [31:0] a,
                                              input logic [31:0] y,
                                              input logic [31:0] n);
        return y * n + a;
    endfunction

    // input word fields
    logic [1:0]         in_req;
    logic [3:0]         in_x;
    logic [5:0]         in_y;
    logic [3:0]         in_z;
    logic [7:0]         in_id;
    logic [1:0]         in_side;
    logic               in_nair;
    logic               in_x_ok;
    logic               in_y_ok;
    logic               in_z_ok;
    logic               s_accept;

    assign in_req  = s_tuser[1:0];
    assign in_x    = s_tdata[3:0];
    assign in_y    = s_tdata[9:4];
    assign in_z    = s_tdata[13:10];
    assign in_id   = s_tdata[21:14];
    assign in_side = s_tdata[23:22];
    assign in_nair = s_tdata[24];

    assign in_x_ok = 32'(in_x) < SIZE_X;
    assign in_y_ok = 32'(in_y) < SIZE_Y;
    assign in_z_ok = 32'(in_z) < SIZE_Z;

    // control state
    state_t             state_reg, state_next;
    logic [CLR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [2:0]         face_reg, face_next;
    src_t               pend_src_reg, pend_src_next;
    logic [2:0]         pend_face_reg, pend_face_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [CFG_W-1:0]   air_id_reg;

    // query payload
    logic [3:0]         qx_reg;
    logic [5:0]         qy_reg;
    logic [3:0]         qz_reg;
    logic               q_in_chunk_reg;
    logic [FACE_W-1:0]  mask_reg, mask_next;
    logic               solid_reg, solid_next;
    logic [FACE_W-1:0]  out_mask_reg;
    logic               out_solid_reg;

    // store ports
    logic               blk_we;
    logic [CELL_AW-1:0] blk_waddr;
    logic [ID_BITS-1:0] blk_wdata;
    logic [CELL_AW-1:0] blk_raddr;
    logic [ID_BITS-1:0] blk_rdata;
    logic               edge_we;
    logic [EDGE_AW-1:0] edge_waddr;
    logic               edge_wdata;
    logic [EDGE_AW-1:0] edge_raddr;
    logic               edge_rdata;

    logic               blk_air;
    logic               face_vis;
    logic               out_free;
    logic               out_load;
    logic               clr_last;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {1'b0, out_solid_reg, out_mask_reg};

    assign out_free  = !m_tvalid_reg || m_tready;
    assign clr_last  = (32'(clr_cnt_reg) == CLEAR_LEN - 1);
    assign blk_air   = (blk_rdata == ID_BITS'(air_id_reg));

    // block id store and edge flag store
    vfv_ram #(
        .DEPTH (CELLS),
        .WIDTH (ID_BITS)
    ) u_block_store (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .raddr (blk_raddr),
        .rdata (blk_rdata)
    );

    vfv_ram #(
        .DEPTH (EDGE_DEPTH),
        .WIDTH (1)
    ) u_edge_store (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_accept && in_req == REQ_QUERY)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (face_reg == FACE_NEG_Y)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST, ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // store access, read scheduling and result collection
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        face_next      = face_reg;
        pend_src_next  = SRC_NONE;
        pend_face_next = pend_face_reg;
        blk_we         = 1'b0;
        blk_waddr      = CELL_AW'(cell_lin(32'(in_x), 32'(in_y), 32'(in_z)));
        blk_wdata      = ID_BITS'(in_id);
        blk_raddr      = CELL_AW'(cell_lin(32'(in_x), 32'(in_y), 32'(in_z)));
        edge_we        = 1'b0;
        edge_waddr     = '0;
        edge_wdata     = in_nair;
        edge_raddr     = '0;
        out_load       = 1'b0;
        face_vis       = 1'b0;
        mask_next      = mask_reg;
        solid_next     = solid_reg;

        // answer of the read issued last cycle
        unique case (pend_src_reg)
            SRC_CENTER: solid_next = q_in_chunk_reg && !blk_air;
            SRC_BLOCK:  face_vis   = blk_air;
            SRC_EDGE:   face_vis   = edge_rdata;
            SRC_ONE:    face_vis   = 1'b1;
            SRC_ZERO:   face_vis   = 1'b0;
            default:    face_vis   = 1'b0;
        endcase
        if (pend_src_reg != SRC_NONE && pend_src_reg != SRC_CENTER)
        begin
            mask_next[pend_face_reg] = face_vis;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // reset sweep: ids to zero, edge flags to air
                blk_we       = 32'(clr_cnt_reg) < CELLS;
                blk_waddr    = clr_cnt_reg[CELL_AW-1:0];
                blk_wdata    = '0;
                edge_we      = 32'(clr_cnt_reg) < EDGE_DEPTH;
                edge_waddr   = clr_cnt_reg[EDGE_AW-1:0];
                edge_wdata   = 1'b1;
                clr_cnt_next = clr_cnt_reg + CLR_W'(1);
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    unique case (in_req)
                        REQ_WRITE_BLOCK:
                        begin
                            blk_we = in_x_ok && in_y_ok && in_z_ok;
                        end
                        REQ_WRITE_EDGE:
                        begin
                            if (in_side == SIDE_FRONT || in_side == SIDE_BACK)
                            begin
                                edge_we    = in_x_ok && in_y_ok;
                                edge_waddr = {in_side, PLANE_AW'(plane_lin(
                                    32'(in_x), 32'(in_y), SIZE_X))};
                            end
                            else
                            begin
                                edge_we    = in_z_ok && in_y_ok;
                                edge_waddr = {in_side, PLANE_AW'(plane_lin(
                                    32'(in_z), 32'(in_y), SIZE_Z))};
                            end
                        end
                        REQ_QUERY:
                        begin
                            // center read goes out with the accept
                            pend_src_next = SRC_CENTER;
                            face_next     = FACE_POS_Z;
                            mask_next     = '0;
                        end
                        default:
                        begin
                            blk_we = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                pend_face_next = face_reg;
                face_next      = face_reg + 3'd1;
                pend_src_next  = SRC_BLOCK;
                unique case (face_reg)
                    FACE_POS_Z:
                    begin
                        if (32'(qz_reg) == SIZE_Z - 1)
                        begin
                            pend_src_next = SRC_EDGE;
                            edge_raddr    = {SIDE_FRONT, PLANE_AW'(plane_lin(
                                32'(qx_reg), 32'(qy_reg), SIZE_X))};
                        end
                        blk_raddr = CELL_AW'(cell_lin(32'(qx_reg), 32'(qy_reg),
                                                      32'(qz_reg) + 32'd1));
                    end
                    FACE_POS_X:
                    begin
                        if (32'(qx_reg) == SIZE_X - 1)
                        begin
                            pend_src_next = SRC_EDGE;
                            edge_raddr    = {SIDE_RIGHT, PLANE_AW'(plane_lin(
                                32'(qz_reg), 32'(qy_reg), SIZE_Z))};
                        end
                        blk_raddr = CELL_AW'(cell_lin(32'(qx_reg) + 32'd1,
                                                      32'(qy_reg), 32'(qz_reg)));
                    end
                    FACE_NEG_Z:
                    begin
                        if (qz_reg == 4'd0)
                        begin
                            pend_src_next = SRC_EDGE;
                            edge_raddr    = {SIDE_BACK, PLANE_AW'(plane_lin(
                                32'(qx_reg), 32'(qy_reg), SIZE_X))};
                        end
                        blk_raddr = CELL_AW'(cell_lin(32'(qx_reg), 32'(qy_reg),
                                                      32'(qz_reg) - 32'd1));
                    end
                    FACE_NEG_X:
                    begin
                        if (qx_reg == 4'd0)
                        begin
                            pend_src_next = SRC_EDGE;
                            edge_raddr    = {SIDE_LEFT, PLANE_AW'(plane_lin(
                                32'(qz_reg), 32'(qy_reg), SIZE_Z))};
                        end
                        blk_raddr = CELL_AW'(cell_lin(32'(qx_reg) - 32'd1,
                                                      32'(qy_reg), 32'(qz_reg)));
                    end
                    FACE_POS_Y:
                    begin
                        // top border is open sky
                        if (32'(qy_reg) == SIZE_Y - 1)
                        begin
                            pend_src_next = SRC_ONE;
                        end
                        blk_raddr = CELL_AW'(cell_lin(32'(qx_reg),
                                                      32'(qy_reg) + 32'd1, 32'(qz_reg)));
                    end
                    FACE_NEG_Y:
                    begin
                        // bottom border is never shown
                        if (qy_reg == 6'd0)
                        begin
                            pend_src_next = SRC_ZERO;
                        end
                        blk_raddr = CELL_AW'(cell_lin(32'(qx_reg),
                                                      32'(qy_reg) - 32'd1, 32'(qz_reg)));
                    end
                    default:
                    begin
                        pend_src_next = SRC_NONE;
                    end
                endcase
            end
            ST_LAST, ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // output word handshake
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            face_reg      <= FACE_POS_Z;
            pend_src_reg  <= SRC_NONE;
            pend_face_reg <= FACE_POS_Z;
            m_tvalid_reg  <= 1'b0;
            air_id_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            face_reg      <= face_next;
            pend_src_reg  <= pend_src_next;
            pend_face_reg <= pend_face_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                air_id_reg <= cfg_data;
            end
        end
    end

    // query and result payload
    always_ff @(posedge clk)
    begin
        mask_reg  <= mask_next;
        solid_reg <= solid_next;
        if (s_accept && in_req == REQ_QUERY)
        begin
            qx_reg         <= in_x;
            qy_reg         <= in_y;
            qz_reg         <= in_z;
            q_in_chunk_reg <= in_x_ok && in_y_ok && in_z_ok;
        end
        if (out_load)
        begin
            out_mask_reg  <= mask_next & {FACE_W{solid_next}};
            out_solid_reg <= solid_next;
        end
    end

endmodule
